FILE: src/mtvt_pkg.sv
// Package for the mip tile visibility tracker.
// Holds field widths, codes, the level base table and controller types.
// No dependencies.
package mtvt_pkg;

  localparam int MAX_LEVELS_DEF  = 8;
  localparam int TOTAL_TILES_DEF = 21845;
  localparam int FRAME_BITS_DEF  = 32;

  localparam int LVL_W    = 3;
  localparam int COORD_W  = 7;
  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 15;
  localparam int KEEP_W   = 16;
  localparam int NL_W     = 4;
  localparam int IDX_W    = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [0:0] OP_VISIBLE   = 1'b0;
  localparam logic [0:0] OP_NEW_FRAME = 1'b1;

  localparam logic [KIND_W-1:0] KIND_TILE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STATS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ALIVE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS     = 8'd1;

  localparam logic [NL_W-1:0] LEVELS_RESET = 4'd8;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_CHECK,
    S_FLUSH,
    S_ERR,
    S_STAT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic load_in;
    logic clr_step;
    logic mem_rd;
    logic mark;
    logic emit_pend;
    logic pend_last;
    logic emit_err;
    logic emit_stat;
    logic stat_next;
    logic frame_adv;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_valid;
    logic new_frame;
    logic err;
    logic oob;
    logic nl_zero;
    logic marked;
    logic lvl_zero;
    logic pend_valid;
    logic out_free;
    logic stat_last;
  } status_t;

  function automatic logic [IDX_W-1:0] level_base(input logic [LVL_W-1:0] l);
    logic [IDX_W-1:0] b;
    unique case (l)
      3'd0: b = 16'd0;
      3'd1: b = 16'd1;
      3'd2: b = 16'd5;
      3'd3: b = 16'd21;
      3'd4: b = 16'd85;
      3'd5: b = 16'd341;
      3'd6: b = 16'd1365;
      3'd7: b = 16'd5461;
      default: b = 16'd0;
    endcase
    return b;
  endfunction

endpackage

FILE: src/mtvt_if.sv
// Channel interfaces of the mip tile visibility tracker.
// Depends on mtvt_pkg.
interface mtvt_req_if import mtvt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [0:0]         opcode;
  logic [LVL_W-1:0]   level;
  logic [COORD_W-1:0] tile_x;
  logic [COORD_W-1:0] tile_y;
  modport source (output valid, opcode, level, tile_x, tile_y, input ready);
  modport sink (input valid, opcode, level, tile_x, tile_y, output ready);
endinterface

interface mtvt_rsp_if import mtvt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [LVL_W-1:0]   out_level;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic               became_alive;
  logic [COUNT_W-1:0] visible_count;
  logic [COUNT_W-1:0] alive_count;
  logic               last;
  modport source (output valid, kind, out_level, out_x, out_y, became_alive,
                  visible_count, alive_count, last, input ready);
  modport sink (input valid, kind, out_level, out_x, out_y, became_alive,
                visible_count, alive_count, last, output ready);
endinterface

interface mtvt_cfg_if import mtvt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/mip_tile_visibility_tracker_unit.sv
// Top level of the mip tile visibility tracker.
// Depends on mtvt_pkg, mtvt_if, mtvt_ctrl and mtvt_dp.
//
//   channel | modport | moves
//   req     | sink    | tile visible or new frame request
//   rsp     | source  | marked tile, level statistics row or error
//   cfg     | sink    | register write: 0 keep-alive frames, 1 levels in use
//
// After the accept cycle a tile request does a store read, then an update or stop, for
// each tile looked up, and a flush step if the walk marks level 0; update, stop and
// flush wait while the output register is full. A new-frame request takes a lookup
// step plus one step per statistics row, an error a lookup step and an error step.
// After reset the tile store is cleared one entry at a time with no request accepted.
// Results stall in the output register while rsp.ready is low.
module mip_tile_visibility_tracker_unit import mtvt_pkg::*; #(
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int TOTAL_TILES = TOTAL_TILES_DEF,
  parameter int FRAME_BITS  = FRAME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mtvt_req_if.sink   req,
  mtvt_rsp_if.source rsp,
  mtvt_cfg_if.sink   cfg
);

  cmd_t    cmd;
  status_t status;

  mtvt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  mtvt_dp #(
    .MAX_LEVELS  (MAX_LEVELS),
    .TOTAL_TILES (TOTAL_TILES),
    .FRAME_BITS  (FRAME_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status)
  );

endmodule

FILE: src/mtvt_ctrl.sv
// Controller of the mip tile visibility tracker: clear pass, walk and stats sequencing.
// Depends on mtvt_pkg; drives commands to mtvt_dp.
module mtvt_ctrl import mtvt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (status.clr_done) state_next = S_IDLE;
      S_IDLE:  if (status.in_valid) state_next = S_LOOK;
      S_LOOK: begin
        if (status.new_frame)       state_next = status.nl_zero ? S_IDLE : S_STAT;
        else if (status.err)        state_next = S_ERR;
        else if (status.oob)        state_next = status.pend_valid ? S_FLUSH : S_IDLE;
        else                        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.out_free) begin
          if (status.marked)        state_next = S_IDLE;
          else if (status.lvl_zero) state_next = S_FLUSH;
          else                      state_next = S_LOOK;
        end
      end
      S_FLUSH: if (status.out_free) state_next = S_IDLE;
      S_ERR:   if (status.out_free) state_next = S_IDLE;
      S_STAT:  if (status.out_free && status.stat_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load_in  = status.in_valid;
      end
      S_LOOK: begin
        if (status.new_frame) begin
          cmd.frame_adv = status.nl_zero;
        end else if (!status.err && !status.oob) begin
          cmd.mem_rd = 1'b1;
        end
      end
      S_CHECK: begin
        if (status.out_free) begin
          cmd.emit_pend = status.pend_valid;
          cmd.pend_last = status.marked;
          cmd.mark      = !status.marked;
        end
      end
      S_FLUSH: begin
        cmd.emit_pend = status.out_free;
        cmd.pend_last = 1'b1;
      end
      S_ERR: cmd.emit_err = status.out_free;
      S_STAT: begin
        cmd.emit_stat = status.out_free;
        cmd.stat_next = status.out_free;
        cmd.frame_adv = status.out_free && status.stat_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: src/mtvt_dp.sv
// Datapath of the mip tile visibility tracker: tile store, counts, frame, walk registers.
// Depends on mtvt_pkg and mtvt_if; controlled by mtvt_ctrl.
module mtvt_dp import mtvt_pkg::*; #(
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int TOTAL_TILES = TOTAL_TILES_DEF,
  parameter int FRAME_BITS  = FRAME_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  mtvt_req_if.sink     req,
  mtvt_rsp_if.source   rsp,
  mtvt_cfg_if.sink     cfg,
  input  cmd_t         cmd,
  output status_t      status
);

  localparam int ADDR_W = (TOTAL_TILES > 1) ? $clog2(TOTAL_TILES) : 1;
  localparam int CMP_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
  localparam int LI_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int SUM_W  = ((FRAME_BITS > KEEP_W) ? FRAME_BITS : KEEP_W) + 1;
  localparam int WORD_W = FRAME_BITS + 1;

  logic [KEEP_W-1:0]     keep_alive;
  logic [NL_W-1:0]       levels_cfg;
  logic [FRAME_BITS-1:0] frame;

  logic [0:0]         opcode;
  logic [LVL_W-1:0]   lvl;
  logic [COORD_W-1:0] x, y;

  logic               pend_valid;
  logic [LVL_W-1:0]   pend_lvl;
  logic [COORD_W-1:0] pend_x, pend_y;
  logic               pend_ba;

  logic [WORD_W-1:0] mem [TOTAL_TILES];
  logic [WORD_W-1:0] rd_data;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] clr_cnt;

  logic [COUNT_W-1:0] vis_cnt [MAX_LEVELS];
  logic [COUNT_W-1:0] alv_cnt [MAX_LEVELS];
  logic [NL_W-1:0]    stat_lvl;

  logic               out_valid;
  logic [KIND_W-1:0]  out_kind;
  logic [LVL_W-1:0]   out_lvl;
  logic [COORD_W-1:0] out_xr, out_yr;
  logic               out_ba;
  logic [COUNT_W-1:0] out_vis, out_alv;
  logic               out_last;

  logic [IDX_W-1:0] idx;
  logic [NL_W-1:0]  nl;
  logic [NL_W-1:0]  lvl_ext;
  logic             alive;
  logic             ba;
  logic             out_free;
  logic [SUM_W-1:0] seen_sum;

  assign idx = level_base(lvl) + (IDX_W'(y) << lvl) + IDX_W'(x);
  assign nl  = (levels_cfg > NL_W'(MAX_LEVELS)) ? NL_W'(MAX_LEVELS) : levels_cfg;
  assign lvl_ext = NL_W'(lvl);
  assign seen_sum = SUM_W'(rd_data[FRAME_BITS-1:0]) + SUM_W'(keep_alive);
  assign alive = rd_data[FRAME_BITS] ? (seen_sum >= SUM_W'(frame)) : (frame == '0);
  assign ba = !alive;
  assign out_free = !out_valid || rsp.ready;

  assign status.clr_done   = (clr_cnt == ADDR_W'(TOTAL_TILES - 1));
  assign status.in_valid   = req.valid;
  assign status.new_frame  = (opcode == OP_NEW_FRAME);
  assign status.err        = (lvl_ext >= nl) || ((x >> lvl) != '0) || ((y >> lvl) != '0);
  assign status.oob        = (CMP_W'(idx) >= CMP_W'(TOTAL_TILES));
  assign status.nl_zero    = (nl == '0);
  assign status.marked     = rd_data[FRAME_BITS] && (rd_data[FRAME_BITS-1:0] == frame);
  assign status.lvl_zero   = (lvl == '0);
  assign status.pend_valid = pend_valid;
  assign status.out_free   = out_free;
  assign status.stat_last  = (stat_lvl == nl - NL_W'(1));

  assign req.ready = cmd.in_ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_alive <= '0;
      levels_cfg <= LEVELS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_KEEP_ALIVE: keep_alive <= cfg.data[KEEP_W-1:0];
        CFG_LEVELS:     levels_cfg <= cfg.data[NL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) mem[clr_cnt] <= '0;
    else if (cmd.mark) mem[addr] <= {1'b1, frame};
    if (cmd.mem_rd) rd_data <= mem[idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) addr <= idx[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_step && !status.clr_done) clr_cnt <= clr_cnt + ADDR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      opcode <= req.opcode;
      lvl    <= req.level;
      x      <= req.tile_x;
      y      <= req.tile_y;
    end else if (cmd.mark && lvl != '0) begin
      lvl <= lvl - LVL_W'(1);
      x   <= x >> 1;
      y   <= y >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.mark) begin
      pend_valid <= 1'b1;
    end else if (cmd.emit_pend && cmd.pend_last) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark) begin
      pend_lvl <= lvl;
      pend_x   <= x;
      pend_y   <= y;
      pend_ba  <= ba;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
    end else if (cmd.frame_adv && frame != '1) begin
      frame <= frame + FRAME_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.frame_adv) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        vis_cnt[i] <= '0;
        alv_cnt[i] <= '0;
      end
    end else if (cmd.mark) begin
      if (vis_cnt[lvl_ext[LI_W-1:0]] != '1)
        vis_cnt[lvl_ext[LI_W-1:0]] <= vis_cnt[lvl_ext[LI_W-1:0]] + COUNT_W'(1);
      if (ba && alv_cnt[lvl_ext[LI_W-1:0]] != '1)
        alv_cnt[lvl_ext[LI_W-1:0]] <= alv_cnt[lvl_ext[LI_W-1:0]] + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in)        stat_lvl <= '0;
    else if (cmd.stat_next) stat_lvl <= stat_lvl + NL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_pend || cmd.emit_err || cmd.emit_stat) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pend) begin
      out_kind <= KIND_TILE;
      out_lvl  <= pend_lvl;
      out_xr   <= pend_x;
      out_yr   <= pend_y;
      out_ba   <= pend_ba;
      out_vis  <= '0;
      out_alv  <= '0;
      out_last <= cmd.pend_last;
    end else if (cmd.emit_err) begin
      out_kind <= KIND_ERROR;
      out_lvl  <= lvl;
      out_xr   <= '0;
      out_yr   <= '0;
      out_ba   <= 1'b0;
      out_vis  <= '0;
      out_alv  <= '0;
      out_last <= 1'b1;
    end else if (cmd.emit_stat) begin
      out_kind <= KIND_STATS;
      out_lvl  <= stat_lvl[LVL_W-1:0];
      out_xr   <= '0;
      out_yr   <= '0;
      out_ba   <= 1'b0;
      out_vis  <= vis_cnt[stat_lvl[LI_W-1:0]];
      out_alv  <= alv_cnt[stat_lvl[LI_W-1:0]];
      out_last <= status.stat_last;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.kind          = out_kind;
  assign rsp.out_level     = out_lvl;
  assign rsp.out_x         = out_xr;
  assign rsp.out_y         = out_yr;
  assign rsp.became_alive  = out_ba;
  assign rsp.visible_count = out_vis;
  assign rsp.alive_count   = out_alv;
  assign rsp.last          = out_last;

endmodule

FILE: tb/sv/tb_mtvt_checker.sv
// Result checker for the mip tile visibility tracker.
// Watches the request, response and register channels, predicts results, compares.
// Depends on mtvt_pkg and mtvt_if.
`timescale 1ns / 1ps
module tb_mtvt_checker import mtvt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  mtvt_req_if    req,
  mtvt_rsp_if    rsp,
  mtvt_cfg_if    cfg,
  output int     fail_count,
  output int     pending,
  output int     result_count
);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [LVL_W-1:0]   lvl;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               alive;
    logic [COUNT_W-1:0] vis;
    logic [COUNT_W-1:0] alv;
    logic               last;
  } tile_result_t;

  tile_result_t       expected_results[$];
  logic [31:0]        seen_frame[TOTAL_TILES_DEF];
  bit                 seen_valid[TOTAL_TILES_DEF];
  logic [31:0]        frame_no;
  logic [COUNT_W-1:0] vis_cnt[MAX_LEVELS_DEF];
  logic [COUNT_W-1:0] alive_cnt[MAX_LEVELS_DEF];
  logic [KEEP_W-1:0]  keep_alive;
  logic [NL_W-1:0]    levels;

  assign pending = expected_results.size();

  function automatic int tile_index(int l, int x, int y);
    return ((1 << (2 * l)) - 1) / 3 + (y << l) + x;
  endfunction

  task automatic predict_request(logic op, int l, int x, int y);
    tile_result_t r;
    int nl;
    int first;
    int idx;
    bit ba;
    nl = (levels > MAX_LEVELS_DEF) ? MAX_LEVELS_DEF : levels;
    first = expected_results.size();
    if (op == OP_NEW_FRAME) begin
      for (int i = 0; i < nl; i++) begin
        r = '0;
        r.kind = KIND_STATS;
        r.lvl = LVL_W'(i);
        r.vis = vis_cnt[i];
        r.alv = alive_cnt[i];
        expected_results = {expected_results, r};
      end
      for (int i = 0; i < MAX_LEVELS_DEF; i++) begin
        vis_cnt[i] = '0;
        alive_cnt[i] = '0;
      end
      if (frame_no != 32'hFFFF_FFFF) frame_no++;
    end else if (l >= nl || x >= (1 << l) || y >= (1 << l)) begin
      r = '0;
      r.kind = KIND_ERROR;
      r.lvl = LVL_W'(l);
      expected_results = {expected_results, r};
    end else begin
      forever begin
        idx = tile_index(l, x, y);
        if (seen_valid[idx] && seen_frame[idx] == frame_no) break;
        if (!seen_valid[idx]) ba = (frame_no != 0);
        else ba = !(64'(seen_frame[idx]) + keep_alive >= 64'(frame_no));
        if (vis_cnt[l] != 15'h7FFF) vis_cnt[l]++;
        if (ba && alive_cnt[l] != 15'h7FFF) alive_cnt[l]++;
        seen_frame[idx] = frame_no;
        seen_valid[idx] = 1'b1;
        r = '0;
        r.kind = KIND_TILE;
        r.lvl = LVL_W'(l);
        r.x = COORD_W'(x);
        r.y = COORD_W'(y);
        r.alive = ba;
        expected_results = {expected_results, r};
        if (l == 0) break;
        l--;
        x >>= 1;
        y >>= 1;
      end
    end
    if (expected_results.size() > first)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endtask

  task automatic compare_result();
    tile_result_t e;
    if (expected_results.size() == 0) begin
      $error("unexpected result kind=%0d level=%0d", rsp.kind, rsp.out_level);
      fail_count++;
      return;
    end
    e = expected_results[0];
    expected_results.delete(0);
    if (rsp.kind !== e.kind) begin
      $error("kind exp %0d got %0d", e.kind, rsp.kind); fail_count++;
    end
    if (rsp.out_level !== e.lvl) begin
      $error("out_level exp %0d got %0d", e.lvl, rsp.out_level); fail_count++;
    end
    if (rsp.out_x !== e.x) begin
      $error("out_x exp %0d got %0d", e.x, rsp.out_x); fail_count++;
    end
    if (rsp.out_y !== e.y) begin
      $error("out_y exp %0d got %0d", e.y, rsp.out_y); fail_count++;
    end
    if (rsp.became_alive !== e.alive) begin
      $error("became_alive exp %0d got %0d", e.alive, rsp.became_alive); fail_count++;
    end
    if (rsp.visible_count !== e.vis) begin
      $error("visible_count exp %0d got %0d", e.vis, rsp.visible_count); fail_count++;
    end
    if (rsp.alive_count !== e.alv) begin
      $error("alive_count exp %0d got %0d", e.alv, rsp.alive_count); fail_count++;
    end
    if (rsp.last !== e.last) begin
      $error("last exp %0d got %0d", e.last, rsp.last); fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      for (int i = 0; i < TOTAL_TILES_DEF; i++) begin
        seen_frame[i] = '0;
        seen_valid[i] = 1'b0;
      end
      for (int i = 0; i < MAX_LEVELS_DEF; i++) begin
        vis_cnt[i] = '0;
        alive_cnt[i] = '0;
      end
      frame_no = '0;
      keep_alive = '0;
      levels = LEVELS_RESET;
      fail_count = 0;
      result_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        compare_result();
        result_count++;
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_KEEP_ALIVE) keep_alive = cfg.data[KEEP_W-1:0];
        else if (cfg.index == CFG_LEVELS) levels = cfg.data[NL_W-1:0];
      end
      if (req.valid && req.ready)
        predict_request(req.opcode, req.level, req.tile_x, req.tile_y);
    end
  end

  final begin
    if (expected_results.size() != 0)
      $display("%0d results still outstanding", expected_results.size());
  end

endmodule

FILE: tb/sv/tb_mip_tile_visibility_tracker_unit.sv
// Testbench top for the mip tile visibility tracker unit.
// Drives requests and register writes, stalls the response side, gives the verdict.
// Depends on mtvt_pkg, mtvt_if, the unit and tb_mtvt_checker.
`timescale 1ns / 1ps
module tb_mip_tile_visibility_tracker_unit;
  import mtvt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   result_count;
  int   cycles = 0;
  int   sent;
  bit   long_gaps;

  mtvt_req_if req ();
  mtvt_rsp_if rsp ();
  mtvt_cfg_if cfg ();

  mip_tile_visibility_tracker_unit dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  tb_mtvt_checker u_checker (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg),
                             .fail_count(fail_count), .pending(pending),
                             .result_count(result_count));

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!long_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // hold ready low for random stretches
  initial begin
    rsp.ready = 1'b0;
    @(posedge clk);
    forever begin
      rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (long_gaps && $urandom_range(0, 2) == 0) begin
        rsp.ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  task automatic send_request(logic op, int l, int x, int y);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= op;
    req.level <= LVL_W'(l);
    req.tile_x <= COORD_W'(x);
    req.tile_y <= COORD_W'(y);
    do @(posedge clk); while (!req.ready);
    sent++;
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_walk(int nl);
    int l;
    l = $urandom_range(0, nl - 1);
    send_request(OP_VISIBLE, l, $urandom_range(0, (1 << l) - 1),
                 $urandom_range(0, (1 << l) - 1));
  endtask

  task automatic random_phase(int count, int nl);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 75) send_walk(nl);
      else if (r < 87) send_request(OP_NEW_FRAME, 0, 0, 0);
      else send_request(1'($urandom_range(0, 1)), $urandom_range(0, 7),
                        $urandom_range(0, 127), $urandom_range(0, 127));
    end
  endtask

  initial begin
    rst = 1'b1;
    sent = 0;
    long_gaps = 1'b0;
    req.valid = 1'b0;
    req.opcode = OP_VISIBLE;
    req.level = '0;
    req.tile_x = '0;
    req.tile_y = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_KEEP_ALIVE;
    cfg.data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: corners, parent hits, errors, stats, frames
    send_request(OP_VISIBLE, 0, 0, 0);
    send_request(OP_VISIBLE, 7, 127, 127);
    send_request(OP_VISIBLE, 7, 127, 126);
    send_request(OP_VISIBLE, 7, 127, 127);
    send_request(OP_VISIBLE, 7, 0, 0);
    send_request(OP_VISIBLE, 1, 2, 0);
    send_request(OP_VISIBLE, 0, 1, 0);
    send_request(OP_VISIBLE, 3, 0, 8);
    send_request(OP_NEW_FRAME, 0, 0, 0);
    send_request(OP_VISIBLE, 7, 127, 127);
    send_request(OP_VISIBLE, 5, 31, 0);
    send_request(OP_NEW_FRAME, 7, 127, 127);
    send_request(OP_VISIBLE, 7, 127, 127);
    send_request(OP_NEW_FRAME, 0, 0, 0);
    write_register(CFG_KEEP_ALIVE, 65535);
    write_register(CFG_LEVELS, 1);
    send_request(OP_VISIBLE, 1, 0, 0);
    send_request(OP_VISIBLE, 0, 0, 0);
    send_request(OP_NEW_FRAME, 0, 0, 0);
    write_register(CFG_LEVELS, 0);
    send_request(OP_NEW_FRAME, 0, 0, 0);
    send_request(OP_VISIBLE, 0, 0, 0);
    write_register(CFG_LEVELS, 15);
    send_request(OP_VISIBLE, 6, 63, 63);
    send_request(OP_NEW_FRAME, 0, 0, 0);

    long_gaps = 1'b1;
    write_register(CFG_KEEP_ALIVE, 0);
    write_register(CFG_LEVELS, 8);
    random_phase(90, 8);
    write_register(CFG_KEEP_ALIVE, 2);
    write_register(CFG_LEVELS, 4);
    random_phase(90, 4);
    write_register(CFG_KEEP_ALIVE, $urandom_range(0, 65535));
    write_register(CFG_LEVELS, $urandom_range(1, 8));
    random_phase(90, 8);
    write_register(CFG_KEEP_ALIVE, 1);
    write_register(CFG_LEVELS, 8);
    random_phase(90, 8);

    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d requests over keep-alive and level settings incl. extremes,",
             sent);
    $display("checked %0d results of tiles, statistics and errors.", result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/mtvt_pkg.sv
src/mtvt_if.sv
src/mtvt_ctrl.sv
src/mtvt_dp.sv
src/mip_tile_visibility_tracker_unit.sv
tb/sv/tb_mtvt_checker.sv
tb/sv/tb_mip_tile_visibility_tracker_unit.sv
